### rtl/rcc_pkg.sv
package rcc_pkg;

  localparam int COORD_W = 7;
  localparam int CELL_W  = 17;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] RECT_LIMIT = 16'hFFFF;

  // Configuration register indexes.
  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_FINISH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_ADD,
    S_ADD_DRAIN,
    S_SCAN,
    S_SCAN_DRAIN,
    S_READ
  } seq_state_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] row_first;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] row_last;
    logic [COORD_W-1:0] col_last;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } read_resp_t;

endpackage

### rtl/rcc_ram.sv
module rcc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rcc_seq.sv
module rcc_seq import rcc_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  item_t              item,
  input  logic [COORD_W-1:0] rows_eff,
  input  logic [COORD_W-1:0] cols_eff,
  input  logic               out_free,
  output logic               ready,
  output read_resp_t         resp
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS << CW;
  localparam logic [AW-1:0] WIPE_LAST = AW'(DEPTH - 1);

  seq_state_t state, state_next;

  logic [AW-1:0]      wipe_addr;
  logic               wipe_last;
  logic               integrated;
  logic [COUNT_W-1:0] taken;

  // Item fields held for the duration of an item.
  logic [COORD_W-1:0] rows_l, cols_l;
  logic [RW-1:0]      row_a, row_c;
  logic [CW-1:0]      col_b, col_d;
  logic               row_c_ok, col_d_ok;
  logic [AW-1:0]      read_addr;
  status_t            read_status;

  logic [1:0]         corner;
  logic [AW-1:0]      corner_addr;
  logic               corner_ok, corner_neg;

  logic               scan_pass;
  logic [COORD_W-1:0] line, pos;
  logic [COORD_W-1:0] inner_end, outer_end;
  logic               pos_last, line_last, scan_done;
  logic [AW-1:0]      scan_addr;

  // Write-back stage: the word read in the previous cycle is modified here.
  logic               p_valid, p_scan, p_keep, p_neg;
  logic [AW-1:0]      p_addr;
  logic [CELL_W-1:0]  running;
  logic [CELL_W-1:0]  add_sum, scan_sum;

  logic [COORD_W-1:0] row_f_m1, col_f_m1;
  logic [AW-1:0]      item_addr;
  logic               add_ok;
  status_t            item_status;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  rcc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Item decode.
  always_comb begin
    row_f_m1  = item.row_first - COORD_W'(1);
    col_f_m1  = item.col_first - COORD_W'(1);
    item_addr = {RW'(row_f_m1), CW'(col_f_m1)};
    add_ok = !integrated && (taken != RECT_LIMIT) &&
             (item.row_first != '0) && (item.col_first != '0) &&
             (item.row_last >= item.row_first) && (item.col_last >= item.col_first) &&
             (item.row_last <= rows_eff) && (item.col_last <= cols_eff);
    if (!integrated) begin
      item_status = ST_NOT_READY;
    end else if ((item.row_first == '0) || (item.col_first == '0) ||
                 (item.row_first > rows_eff) || (item.col_first > cols_eff)) begin
      item_status = ST_RANGE;
    end else begin
      item_status = ST_OK;
    end
  end

  // Corner zero is read during the accept cycle, so corners one to three remain.
  always_comb begin
    unique case (corner)
      2'd1: begin
        corner_addr = {row_c, col_d};
        corner_ok   = row_c_ok && col_d_ok;
        corner_neg  = 1'b0;
      end
      2'd2: begin
        corner_addr = {row_a, col_d};
        corner_ok   = col_d_ok;
        corner_neg  = 1'b1;
      end
      2'd3: begin
        corner_addr = {row_c, col_b};
        corner_ok   = row_c_ok;
        corner_neg  = 1'b1;
      end
      default: begin
        corner_addr = {row_a, col_b};
        corner_ok   = 1'b1;
        corner_neg  = 1'b0;
      end
    endcase
  end

  // The column pass walks column by column, so both passes keep one running sum.
  always_comb begin
    inner_end = scan_pass ? cols_l : rows_l;
    outer_end = scan_pass ? rows_l : cols_l;
    pos_last  = (pos == inner_end - COORD_W'(1));
    line_last = (line == outer_end - COORD_W'(1));
    scan_done = scan_pass && pos_last && line_last;
    scan_addr = scan_pass ? {RW'(line), CW'(pos)} : {RW'(pos), CW'(line)};
  end

  always_comb begin
    unique case (state)
      S_ADD:   ram_raddr = corner_addr;
      S_SCAN:  ram_raddr = scan_addr;
      S_READ:  ram_raddr = read_addr;
      default: ram_raddr = item_addr;
    endcase
  end

  always_comb begin
    wipe_last = (wipe_addr == WIPE_LAST);
    add_sum   = ram_rdata + (p_neg ? {CELL_W{1'b1}} : CELL_W'(1));
    scan_sum  = ram_rdata + running;
    if (state == S_WIPE) begin
      ram_we    = 1'b1;
      ram_waddr = wipe_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = p_valid && p_keep;
      ram_waddr = p_addr;
      ram_wdata = p_scan ? scan_sum : add_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ready        = 1'b0;
    resp.valid   = 1'b0;
    resp.status  = read_status;
    resp.count   = (read_status == ST_OK) ? ram_rdata[COUNT_W-1:0] : '0;
    unique case (state)
      S_WIPE: begin
        if (wipe_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ready = 1'b1;
        if (take) begin
          unique case (item.op)
            OP_CLEAR:  state_next = S_WIPE;
            OP_ADD:    state_next = add_ok ? S_ADD : S_IDLE;
            OP_FINISH: state_next = integrated ? S_IDLE : S_SCAN;
            OP_READ:   state_next = S_READ;
          endcase
        end
      end
      S_ADD: begin
        if (corner == 2'd3) begin
          state_next = S_ADD_DRAIN;
        end
      end
      S_ADD_DRAIN: state_next = S_IDLE;
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_SCAN_DRAIN;
        end
      end
      S_SCAN_DRAIN: state_next = S_IDLE;
      S_READ: begin
        resp.valid = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wipe_addr  <= '0;
      integrated <= 1'b0;
      taken      <= '0;
      p_valid    <= 1'b0;
      corner     <= '0;
      scan_pass  <= 1'b0;
      line       <= '0;
      pos        <= '0;
    end else begin
      p_valid <= 1'b0;
      if (state == S_WIPE) begin
        wipe_addr <= wipe_last ? '0 : wipe_addr + AW'(1);
      end
      if ((state == S_IDLE) && take) begin
        unique case (item.op)
          OP_CLEAR: begin
            integrated <= 1'b0;
            taken      <= '0;
          end
          OP_ADD: begin
            if (add_ok) begin
              taken   <= taken + COUNT_W'(1);
              p_valid <= 1'b1;
              corner  <= 2'd1;
            end
          end
          OP_FINISH: begin
            if (!integrated) begin
              integrated <= 1'b1;
              scan_pass  <= 1'b0;
              line       <= '0;
              pos        <= '0;
            end
          end
          OP_READ: begin
          end
        endcase
      end
      if (state == S_ADD) begin
        p_valid <= 1'b1;
        corner  <= corner + 2'd1;
      end
      if (state == S_SCAN) begin
        p_valid <= 1'b1;
        if (pos_last) begin
          pos <= '0;
          if (line_last) begin
            line      <= '0;
            scan_pass <= 1'b1;
          end else begin
            line <= line + COORD_W'(1);
          end
        end else begin
          pos <= pos + COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && take) begin
      rows_l      <= rows_eff;
      cols_l      <= cols_eff;
      row_a       <= RW'(row_f_m1);
      col_b       <= CW'(col_f_m1);
      row_c       <= RW'(item.row_last);
      col_d       <= CW'(item.col_last);
      row_c_ok    <= item.row_last < rows_eff;
      col_d_ok    <= item.col_last < cols_eff;
      read_addr   <= item_addr;
      read_status <= item_status;
      p_addr      <= item_addr;
      p_scan      <= 1'b0;
      p_keep      <= 1'b1;
      p_neg       <= 1'b0;
    end else if (state == S_ADD) begin
      p_addr <= corner_addr;
      p_scan <= 1'b0;
      p_keep <= corner_ok;
      p_neg  <= corner_neg;
    end else if (state == S_SCAN) begin
      p_addr <= scan_addr;
      p_scan <= 1'b1;
      p_keep <= (pos != '0);
      p_neg  <= 1'b0;
    end
    // The first word of a line only seeds the running sum.
    if (p_valid && p_scan) begin
      running <= p_keep ? scan_sum : ram_rdata;
    end
  end

  // A corner past the edge may wrap onto a word being written; its read data is unused.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (((state == S_ADD) && corner_ok) || (state == S_SCAN)) && ram_we |->
      ram_raddr != ram_waddr)
    else $error("read and write of the same word in one cycle");

  a_drain_after_corners: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD_DRAIN) |-> ($past(state) == S_ADD) && ($past(corner) == 2'd3))
    else $error("add drain entered before all corners were read");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("memory written while idle");

  a_read_addr_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> ram_raddr == read_addr)
    else $error("read address moved while a result waits");

endmodule

### rtl/rectangle_coverage_counter_2d.sv
// Rectangle coverage counter over a grid of up to MAX_ROWS by MAX_COLS cells, kept as a
// difference grid in one memory with one write and one registered read port per cycle.
// Work per input word: an add makes four corner read-modify-writes, pipelined one per
// cycle, plus a write-back drain; an ignored add and a repeated finish are done at their
// accept, and a clear's accept starts the sweep below; a finish makes a column pass and
// a row pass, each visiting every cell in use once; a read's result may wait on
// out_stall. After reset and after every clear the block sweeps the whole memory of
// MAX_ROWS * 2**ceil(log2(MAX_COLS)) words (4096 at the defaults), with in_stall high;
// configuration writes are taken at all times and are meant to be made while the block
// is idle.
module rectangle_coverage_counter_2d import rcc_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [COORD_W-1:0] row_first,
  input  logic [COORD_W-1:0] col_first,
  input  logic [COORD_W-1:0] row_last,
  input  logic [COORD_W-1:0] col_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] cover_count,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [COORD_W-1:0] cfg_data
);

  logic [COORD_W-1:0] rows_in_use, cols_in_use;
  logic [COORD_W-1:0] rows_eff, cols_eff;
  logic               seq_ready, take, out_free;
  item_t              item;
  read_resp_t         resp;
  logic [COUNT_W-1:0] out_count;
  status_t            out_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= COORD_W'(64);
      cols_in_use <= COORD_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        REG_COLS_IN_USE: cols_in_use <= cfg_data;
      endcase
    end
  end

  // Zero counts as one, and anything beyond the grid as the grid size.
  always_comb begin
    if (rows_in_use == '0) begin
      rows_eff = COORD_W'(1);
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      rows_eff = COORD_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_in_use;
    end
    if (cols_in_use == '0) begin
      cols_eff = COORD_W'(1);
    end else if (int'(cols_in_use) > MAX_COLS) begin
      cols_eff = COORD_W'(MAX_COLS);
    end else begin
      cols_eff = cols_in_use;
    end
  end

  assign in_stall       = !seq_ready;
  assign take           = in_valid && seq_ready;
  assign item.op        = op_t'(operation);
  assign item.row_first = row_first;
  assign item.col_first = col_first;
  assign item.row_last  = row_last;
  assign item.col_last  = col_last;
  assign out_free       = !out_valid || !out_stall;

  rcc_seq #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (item),
    .rows_eff(rows_eff),
    .cols_eff(cols_eff),
    .out_free(out_free),
    .ready   (seq_ready),
    .resp    (resp)
  );

  // Output word register; the sequencer holds its result until this slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= resp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && resp.valid) begin
      out_count  <= resp.count;
      out_status <= resp.status;
    end
  end

  assign cover_count = out_count;
  assign status      = out_status;

endmodule
